// File: hdl/c3dc_pkg.sv
// shared types, constants and register codes of the 3x3 convolution block
package c3dc_pkg;

  // default sizing of the line stores and counters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_SIZE       = 3;

  // field widths
  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int SIZE_W   = 11;
  localparam int DIV_W    = 16;
  localparam int COEF_W   = 16;
  localparam int COEFROW_W = 48;
  localparam int CFG_IDX_W = 3;

  // arithmetic widths
  localparam int PROD_W   = 25;
  localparam int ACC_W    = 28;
  localparam int REM_W    = 24;
  localparam int DIV_STEPS = 8;
  localparam int NUM_TAPS = 9;
  localparam int TAP_W    = 4;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // configuration reset values
  localparam logic [SIZE_W-1:0]    LINE_WIDTH_RST   = 11'd1024;
  localparam logic [SIZE_W-1:0]    FRAME_HEIGHT_RST = 11'd1024;
  localparam logic [DIV_W-1:0]     DIVISOR_RST      = 16'd1;
  localparam logic [COEFROW_W-1:0] COEF_TOP_RST     = 48'd0;
  localparam logic [COEFROW_W-1:0] COEF_MID_RST     = 48'h0000_0001_0000;
  localparam logic [COEFROW_W-1:0] COEF_BOT_RST     = 48'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_DIVISOR      = 3'd2,
    CFG_COEF_TOP     = 3'd3,
    CFG_COEF_MID     = 3'd4,
    CFG_COEF_BOT     = 3'd5
  } cfg_reg_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MAC,
    ST_SAT,
    ST_DIV,
    ST_OUT
  } state_t;

  // input item
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [PIX_W-1:0] filtered_value;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } out_item_t;

  // payload handed from one divider cell to the next
  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [REM_W-1:0]     dsh;
    logic [DIV_STEPS-1:0] quo;
  } div_stage_t;

endpackage

// File: hdl/conv3x3_divide_clamp_core.sv
// 3x3 convolution over one 8-bit plane with divide and clamp, top level
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------
//  in_     | input     | in_valid/in_stall | pixel_value, frame_start
//  out_    | output    | out_valid/out_stall | filtered_value, out_row, out_col,
//          |           |                   | frame_last
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (always ready)
//
// a border pixel is accepted with the line store read, then the window and line
// stores are updated. an interior pixel is accepted, updated, walked through the
// nine taps by the single multiplier, range checked, passed through the chain of
// divider cells and handed to the output register.
// rst_n clears counters, window, config and control; line stores are not cleared.
// a result waiting for a full output register holds the sequencer and stalls
// acceptance until the register is free.
module conv3x3_divide_clamp_core #(
  parameter int MAX_WIDTH  = c3dc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3dc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  c3dc_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output c3dc_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [c3dc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [c3dc_pkg::COEFROW_W-1:0]        cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = c3dc_pkg::PIX_W;
  localparam int NS  = c3dc_pkg::DIV_STEPS;

  // configuration registers
  logic [c3dc_pkg::SIZE_W-1:0]    line_width_r;
  logic [c3dc_pkg::SIZE_W-1:0]    frame_height_r;
  logic [c3dc_pkg::DIV_W-1:0]     divisor_r;
  logic [c3dc_pkg::COEFROW_W-1:0] coef_top_r;
  logic [c3dc_pkg::COEFROW_W-1:0] coef_mid_r;
  logic [c3dc_pkg::COEFROW_W-1:0] coef_bot_r;

  c3dc_pkg::state_t state_r, state_nxt;

  // position counters and per item sideband
  logic [CW-1:0] col_cnt_r;
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic [15:0]   lw_ext;
  logic [15:0]   fh_ext;

  logic                          in_acc;
  logic [PW-1:0]                 px_r;
  logic [CW-1:0]                 idx_r;
  logic                          interior_r;
  logic [c3dc_pkg::POS_W-1:0]    row_o_r;
  logic [c3dc_pkg::POS_W-1:0]    col_o_r;
  logic                          last_r;

  // line stores
  logic [PW-1:0] rd_above;
  logic [PW-1:0] rd_two;
  logic          upd_en;

  // window and weights
  logic [PW-1:0]        win_r [0:c3dc_pkg::NUM_TAPS-1];
  logic signed [15:0]   wt    [0:c3dc_pkg::NUM_TAPS-1];

  // multiply accumulate
  logic [c3dc_pkg::TAP_W-1:0]        mac_k_r;
  logic [c3dc_pkg::TAP_W-1:0]        tap_sel;
  logic signed [c3dc_pkg::PROD_W-1:0] mul_a;
  logic signed [c3dc_pkg::PROD_W-1:0] mul_b;
  logic signed [c3dc_pkg::PROD_W-1:0] prod_r;
  logic signed [c3dc_pkg::ACC_W-1:0]  acc_r;

  // range check and divider chain
  logic [c3dc_pkg::DIV_W-1:0] dsor;
  logic [c3dc_pkg::REM_W-1:0] lim;
  logic                       acc_neg;
  logic                       acc_big;
  logic                       force_zero_r;
  logic                       force_max_r;
  logic                       vld [0:NS];
  c3dc_pkg::div_stage_t       stg [0:NS];

  // result holding and output register
  logic                 slot_free;
  logic [PW-1:0]        res_r;
  logic                 out_valid_r;
  c3dc_pkg::out_item_t  out_data_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= c3dc_pkg::LINE_WIDTH_RST;
      frame_height_r <= c3dc_pkg::FRAME_HEIGHT_RST;
      divisor_r      <= c3dc_pkg::DIVISOR_RST;
      coef_top_r     <= c3dc_pkg::COEF_TOP_RST;
      coef_mid_r     <= c3dc_pkg::COEF_MID_RST;
      coef_bot_r     <= c3dc_pkg::COEF_BOT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        c3dc_pkg::CFG_LINE_WIDTH:   line_width_r   <= cfg_data[c3dc_pkg::SIZE_W-1:0];
        c3dc_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[c3dc_pkg::SIZE_W-1:0];
        c3dc_pkg::CFG_DIVISOR:      divisor_r      <= cfg_data[c3dc_pkg::DIV_W-1:0];
        c3dc_pkg::CFG_COEF_TOP:     coef_top_r     <= cfg_data;
        c3dc_pkg::CFG_COEF_MID:     coef_mid_r     <= cfg_data;
        c3dc_pkg::CFG_COEF_BOT:     coef_bot_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturate the frame size to the supported range
  always_comb begin
    lw_ext = 16'(line_width_r);
    fh_ext = 16'(frame_height_r);
    if (lw_ext < 16'(c3dc_pkg::MIN_SIZE)) begin
      w_sat = WW'(c3dc_pkg::MIN_SIZE);
    end else if (lw_ext > 16'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(lw_ext);
    end
    if (fh_ext < 16'(c3dc_pkg::MIN_SIZE)) begin
      h_sat = HW'(c3dc_pkg::MIN_SIZE);
    end else if (fh_ext > 16'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(fh_ext);
    end
  end

  // position of the incoming item and of the one after it
  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_cnt_r;
    row_cur = in_data.frame_start ? '0 : row_cnt_r;
    if (WW'(col_cur) >= w_sat) begin
      col_cur = '0;
    end
    if (HW'(row_cur) >= h_sat) begin
      row_cur = '0;
    end
    col_inc = WW'(col_cur) + WW'(1);
    row_inc = HW'(row_cur) + HW'(1);
    if (col_inc >= w_sat) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_sat) ? '0 : RW'(row_inc);
    end else begin
      col_nxt = CW'(col_inc);
      row_nxt = row_cur;
    end
  end

  assign in_acc = in_valid && !in_stall;

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // item sideband captured at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r       <= in_data.pixel_value;
      idx_r      <= col_cur;
      interior_r <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
      row_o_r    <= c3dc_pkg::POS_W'(row_cur - RW'(1));
      col_o_r    <= c3dc_pkg::POS_W'(col_cur - CW'(1));
      last_r     <= (HW'(row_cur) == h_sat - HW'(1)) && (WW'(col_cur) == w_sat - WW'(1));
    end
  end

  // line stores: read at acceptance, written back in the update cycle
  assign upd_en = (state_r == c3dc_pkg::ST_UPD);

  c3dc_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_ram_above (
    .clk   (clk),
    .we    (upd_en),
    .waddr (idx_r),
    .wdata (px_r),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (rd_above)
  );

  c3dc_ram #(.DATA_W(PW), .DEPTH(MAX_WIDTH)) u_ram_two (
    .clk   (clk),
    .we    (upd_en),
    .waddr (idx_r),
    .wdata (rd_above),
    .re    (in_acc),
    .raddr (col_cur),
    .rdata (rd_two)
  );

  // window shifts one column per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < c3dc_pkg::NUM_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (upd_en) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= rd_two;
      win_r[3] <= win_r[4];
      win_r[4] <= win_r[5];
      win_r[5] <= rd_above;
      win_r[6] <= win_r[7];
      win_r[7] <= win_r[8];
      win_r[8] <= px_r;
    end
  end

  // unpack the signed weights, left to right per row
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wt[j]     = $signed(coef_top_r[j*c3dc_pkg::COEF_W +: c3dc_pkg::COEF_W]);
      wt[3 + j] = $signed(coef_mid_r[j*c3dc_pkg::COEF_W +: c3dc_pkg::COEF_W]);
      wt[6 + j] = $signed(coef_bot_r[j*c3dc_pkg::COEF_W +: c3dc_pkg::COEF_W]);
    end
  end

  // one tap per cycle through a single multiplier
  always_comb begin
    tap_sel = (mac_k_r < c3dc_pkg::TAP_W'(c3dc_pkg::NUM_TAPS)) ? mac_k_r : '0;
    mul_a   = c3dc_pkg::PROD_W'($signed({1'b0, win_r[tap_sel]}));
    mul_b   = c3dc_pkg::PROD_W'(wt[tap_sel]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_k_r <= '0;
    end else if (upd_en) begin
      mac_k_r <= '0;
    end else if (state_r == c3dc_pkg::ST_MAC) begin
      mac_k_r <= mac_k_r + c3dc_pkg::TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      acc_r <= '0;
    end else if (state_r == c3dc_pkg::ST_MAC) begin
      prod_r <= mul_a * mul_b;
      if (mac_k_r != '0) begin
        acc_r <= acc_r + c3dc_pkg::ACC_W'(prod_r);
      end
    end
  end

  // range check ahead of the divider: negative gives 0, quotient over 255 gives 255
  always_comb begin
    dsor    = (divisor_r == '0) ? c3dc_pkg::DIV_W'(1) : divisor_r;
    lim     = {dsor, 8'd0};
    acc_neg = acc_r[c3dc_pkg::ACC_W-1];
    acc_big = !acc_neg && ((acc_r[c3dc_pkg::ACC_W-2:c3dc_pkg::REM_W] != '0) ||
                           (acc_r[c3dc_pkg::REM_W-1:0] >= lim));
  end

  always_ff @(posedge clk) begin
    if (state_r == c3dc_pkg::ST_SAT) begin
      force_zero_r <= acc_neg;
      force_max_r  <= acc_big;
    end
  end

  // divider chain, one quotient bit per cell
  assign vld[0]     = (state_r == c3dc_pkg::ST_SAT);
  assign stg[0].rem = acc_r[c3dc_pkg::REM_W-1:0];
  assign stg[0].dsh = {1'b0, dsor, 7'd0};
  assign stg[0].quo = '0;

  for (genvar i = 0; i < NS; i++) begin : g_cell
    c3dc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld[i]),
      .in_stg  (stg[i]),
      .out_vld (vld[i+1]),
      .out_stg (stg[i+1])
    );
  end

  // clamped quotient held until the output register is free
  always_ff @(posedge clk) begin
    if (state_r == c3dc_pkg::ST_DIV && vld[NS]) begin
      if (force_zero_r) begin
        res_r <= '0;
      end else if (force_max_r) begin
        res_r <= c3dc_pkg::PIX_MAX;
      end else begin
        res_r <= stg[NS].quo;
      end
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c3dc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and stall
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      c3dc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = c3dc_pkg::ST_UPD;
        end
      end
      c3dc_pkg::ST_UPD: begin
        state_nxt = interior_r ? c3dc_pkg::ST_MAC : c3dc_pkg::ST_IDLE;
      end
      c3dc_pkg::ST_MAC: begin
        if (mac_k_r == c3dc_pkg::TAP_W'(c3dc_pkg::NUM_TAPS)) begin
          state_nxt = c3dc_pkg::ST_SAT;
        end
      end
      c3dc_pkg::ST_SAT: begin
        state_nxt = c3dc_pkg::ST_DIV;
      end
      c3dc_pkg::ST_DIV: begin
        if (vld[NS]) begin
          state_nxt = c3dc_pkg::ST_OUT;
        end
      end
      c3dc_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = c3dc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c3dc_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == c3dc_pkg::ST_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == c3dc_pkg::ST_OUT && slot_free) begin
      out_data_r.filtered_value <= res_r;
      out_data_r.out_row        <= row_o_r;
      out_data_r.out_col        <= col_o_r;
      out_data_r.frame_last     <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the divider result only ever lands while the sequencer waits for it
  a_chain_end_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NS] |-> state_r == c3dc_pkg::ST_DIV)
    else $error("divider result outside the divide wait");

  // a handed over item always shows up on the output
  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == c3dc_pkg::ST_OUT && slot_free) |=> out_valid_r)
    else $error("result item lost at the output register");

  // the two clamp overrides exclude each other
  a_clamp_excl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == c3dc_pkg::ST_DIV |-> !(force_zero_r && force_max_r))
    else $error("both clamp overrides set");

  // the line store index stays inside the current row
  a_idx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == c3dc_pkg::ST_UPD |-> WW'(idx_r) < w_sat)
    else $error("line store index beyond the row");

  // the accumulator walks all nine taps before the range check
  a_mac_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == c3dc_pkg::ST_SAT |-> $past(state_r) == c3dc_pkg::ST_MAC &&
      mac_k_r == c3dc_pkg::TAP_W'(c3dc_pkg::NUM_TAPS + 1))
    else $error("range check before the last tap");

endmodule

// File: hdl/c3dc_ram.sv
// generic single write port memory with registered read
module c3dc_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/c3dc_div_cell.sv
// one restoring division step, registered towards the next cell
module c3dc_div_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  c3dc_pkg::div_stage_t   in_stg,
  output logic                   out_vld,
  output c3dc_pkg::div_stage_t   out_stg
);

  logic                 vld_r;
  c3dc_pkg::div_stage_t stg_r;
  c3dc_pkg::div_stage_t stg_nxt;
  logic                 fits;

  // trial subtract of the shifted divisor
  always_comb begin
    fits          = (in_stg.rem >= in_stg.dsh);
    stg_nxt.rem   = fits ? (in_stg.rem - in_stg.dsh) : in_stg.rem;
    stg_nxt.dsh   = {1'b0, in_stg.dsh[c3dc_pkg::REM_W-1:1]};
    stg_nxt.quo   = {in_stg.quo[c3dc_pkg::DIV_STEPS-2:0], fits};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule
